### sv/fwsk_pkg.sv
// Types, constants and the arctangent table shared by the steering kinematics pipeline.
// No dependencies.
package fwsk_pkg;

   localparam int WheelCount = 4;
   localparam int XW = 34;
   localparam int ZW = 33;
   localparam int AngleMax = 12868;
   localparam int SpeedMax = 65535;
   localparam logic [29:0] InvGain = 30'd652032874;

   localparam logic CSR_TRACK = 1'b0;
   localparam logic CSR_BASE = 1'b1;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 neg;
      logic                 zero;
   } cordic_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] r;
      unique case (idx)
         0: r = 33'sd843314857;
         1: r = 33'sd497837829;
         2: r = 33'sd263043837;
         3: r = 33'sd133525159;
         4: r = 33'sd67021687;
         5: r = 33'sd33543516;
         6: r = 33'sd16775851;
         7: r = 33'sd8388437;
         8: r = 33'sd4194283;
         9: r = 33'sd2097149;
         default: r = ZW'(64'sd1 <<< (30 - idx));
      endcase
      return r;
   endfunction

endpackage

### sv/four_wheel_steer_kinematics.sv
// Four-wheel independent steering inverse kinematics, top level.
// Depends on fwsk_pkg, fwsk_cell and fwsk_finish.
//
// req_ carries one body twist per item (forward velocity, side velocity,
// yaw rate). rsp_ returns one item per twist: the steering angle of each
// wheel in Q2.13 radians and the signed wheel speed in mm/s.
// csr_ writes the track width (index 0) or the wheelbase (index 1); other
// indexes are ignored. Write it only while the pipeline is empty.
// Each wheel runs through its own row of CORDIC_STAGES vectoring cells.
// An accepted item passes input, vector, cell, gain and output registers.
// One item is accepted every cycle while req_tready is high.
// When the receiver stalls, the whole pipeline holds, and req_tready drops
// only while a finished item waits in the output register.
// Reset empties the pipeline and loads the track width with 650 mm and the
// wheelbase with 954 mm.
module four_wheel_steer_kinematics
   import fwsk_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // forward_velocity, side_velocity, yaw_rate
   input  logic [47:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // front_left_angle, front_right_angle, back_left_angle, back_right_angle,
   // front_left_speed, front_right_speed, back_left_speed, back_right_speed
   output logic [127:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [11:0]  csr_data
);

   localparam int Depth = CORDIC_STAGES + 4;

   logic [11:0] track_ff, base_ff;
   logic [Depth-1:0] valid_ff, valid_in;
   logic adv;

   logic signed [15:0] vx_ff, vy_ff;
   logic signed [28:0] ww_ff, wl_ff;
   cordic_type         vec_ff [WheelCount];
   cordic_type         vec_in [WheelCount];
   cordic_type         chain [WheelCount][CORDIC_STAGES+1];
   logic signed [14:0] angle [WheelCount];
   logic signed [16:0] speed [WheelCount];
   logic [127:0]       data_ff;

   assign adv = !valid_ff[Depth-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[Depth-1];
   assign rsp_tdata = data_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= 12'd650;
         base_ff  <= 12'd954;
      end else if (csr_valid && csr_index[1] == 1'b0) begin
         if (csr_index[0] == CSR_TRACK) begin
            track_ff <= csr_data;
         end else if (csr_index[0] == CSR_BASE) begin
            base_ff <= csr_data;
         end
      end
   end

   assign valid_in = {valid_ff[Depth-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff <= req_tdata[15:0];
         vy_ff <= req_tdata[31:16];
         ww_ff <= $signed(req_tdata[47:32]) * $signed({1'b0, track_ff});
         wl_ff <= $signed(req_tdata[47:32]) * $signed({1'b0, base_ff});
      end
   end

   // Corner signs: left wheels sit at -W/2, back wheels at -L/2.
   always_comb begin
      for (int k = 0; k < WheelCount; k++) begin
         logic signed [30:0] cx, cy;
         logic signed [XW-1:0] x, y;
         if (k < 2) begin
            cx = (31'(vx_ff) <<< 13) - 31'(wl_ff);
         end else begin
            cx = (31'(vx_ff) <<< 13) + 31'(wl_ff);
         end
         if (k % 2 == 0) begin
            cy = (31'(vy_ff) <<< 13) - 31'(ww_ff);
         end else begin
            cy = (31'(vy_ff) <<< 13) + 31'(ww_ff);
         end
         x = XW'(cy);
         y = -XW'(cx);
         vec_in[k].neg  = x[XW-1];
         vec_in[k].x    = x[XW-1] ? -x : x;
         vec_in[k].y    = x[XW-1] ? -y : y;
         vec_in[k].z    = '0;
         vec_in[k].zero = (cx == '0) && (cy == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff <= vec_in;
      end
   end

   for (genvar k = 0; k < WheelCount; k++) begin : g_wheel
      assign chain[k][0] = vec_ff[k];
      for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
         fwsk_cell #(.STAGE(s)) u_cell (
            .clock    (clock),
            .enable   (adv),
            .cell_in  (chain[k][s]),
            .cell_out (chain[k][s+1])
         );
      end
      fwsk_finish u_finish (
         .clock   (clock),
         .enable  (adv),
         .cell_in (chain[k][CORDIC_STAGES]),
         .angle   (angle[k]),
         .speed   (speed[k])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= {speed[3], speed[2], speed[1], speed[0],
                     angle[3], angle[2], angle[1], angle[0]};
      end
   end

endmodule

### sv/fwsk_cell.sv
// One CORDIC vectoring cell: rotates the vector by one step and passes it on.
// Depends on fwsk_pkg.
module fwsk_cell
   import fwsk_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       enable,
   input  cordic_type cell_in,
   output cordic_type cell_out
);

   cordic_type cell_ff, cell_in_next;
   logic signed [XW-1:0] dx, dy;

   always_comb begin
      dx = cell_in.y >>> STAGE;
      dy = cell_in.x >>> STAGE;
      cell_in_next = cell_in;
      if (!cell_in.y[XW-1]) begin
         cell_in_next.x = cell_in.x + dx;
         cell_in_next.y = cell_in.y - dy;
         cell_in_next.z = cell_in.z + atan_q30(STAGE);
      end else begin
         cell_in_next.x = cell_in.x - dx;
         cell_in_next.y = cell_in.y + dy;
         cell_in_next.z = cell_in.z - atan_q30(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

### sv/fwsk_finish.sv
// Gain correction, rounding, clamping and sign of one wheel's CORDIC result.
// Depends on fwsk_pkg.
module fwsk_finish
   import fwsk_pkg::*;
(
   input  logic               clock,
   input  logic               enable,
   input  cordic_type         cell_in,
   output logic signed [14:0] angle,
   output logic signed [16:0] speed
);

   logic [61:0]          prod_ff;
   logic signed [ZW-1:0] z_ff;
   logic                 neg_ff, zero_ff;
   logic signed [15:0]   zr;
   logic [62:0]          rnd;
   logic [19:0]          mag;
   logic [16:0]          mag_sat;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= 62'(cell_in.x[31:0]) * 62'(InvGain);
         z_ff    <= cell_in.z;
         neg_ff  <= cell_in.neg;
         zero_ff <= cell_in.zero;
      end
   end

   always_comb begin
      zr = 16'((z_ff + ZW'(65536)) >>> 17);
      rnd = {1'b0, prod_ff} + (63'd1 << 42);
      mag = rnd[62:43];
      mag_sat = (mag > 20'(SpeedMax)) ? 17'(SpeedMax) : mag[16:0];
      if (zero_ff) begin
         angle = '0;
         speed = '0;
      end else begin
         if (zr > 16'sd12868) begin
            angle = 15'(AngleMax);
         end else if (zr < -16'sd12868) begin
            angle = -15'(AngleMax);
         end else begin
            angle = zr[14:0];
         end
         speed = neg_ff ? -$signed(mag_sat) : $signed(mag_sat);
      end
   end

endmodule

### tb/four_wheel_steer_kinematics_tb.sv
// Self-checking testbench for the four-wheel steering kinematics block.
// Needs fwsk_pkg and four_wheel_steer_kinematics; predicts each wheel's angle and speed itself.
// Twists are streamed with random gaps and receiver stalls; geometry changes between phases.
module four_wheel_steer_kinematics_tb;
   import fwsk_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Stages = 16;
   localparam int Settle = Stages + 12;
   localparam int CycleLimit = 600000;
   localparam logic [1:0] RegTrack = {1'b0, CSR_TRACK};
   localparam logic [1:0] RegBase = {1'b0, CSR_BASE};
   localparam logic [1:0] RegSpareA = 2'd2;
   localparam logic [1:0] RegSpareB = 2'd3;
   localparam longint ArcTab[16] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768};

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] side;
      logic signed [15:0] fwd;
   } twist_t;

   typedef struct packed {
      logic [3:0][16:0] spd;
      logic [3:0][14:0] ang;
   } wheels_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [11:0] csr_data = '0;

   four_wheel_steer_kinematics #(.CORDIC_STAGES(Stages)) DUT (.*);

   twist_t twist_queue[$];
   wheels_t wheel_expect[$];
   logic [11:0] track_mm = 12'd650;
   logic [11:0] base_mm = 12'd954;
   int errors = 0;
   int twists_taken = 0;
   int wheel_sets_seen = 0;
   int cycles = 0;
   bit req_took = 1'b0;
   bit idle_on = 1'b1;
   bit long_hold_done = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (!idle_on || r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Vectoring CORDIC on the wheel vector turned by -pi/2, flipped into the right half-plane.
   function automatic void solve_wheel(input longint cx, input longint cy,
                                       output logic [14:0] ang, output logic [16:0] spd);
      longint x, y, z, dx, dy, mag;
      bit flip;
      x = cy;
      y = -cx;
      z = 0;
      flip = 1'b0;
      if (cx == 0 && cy == 0) begin
         ang = '0;
         spd = '0;
         return;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         flip = 1'b1;
      end
      for (int i = 0; i < Stages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += ArcTab[i];
         end else begin
            x -= dx;
            y += dy;
            z -= ArcTab[i];
         end
      end
      z = (z + 64'sd65536) >>> 17;
      if (z > AngleMax) z = AngleMax;
      if (z < -AngleMax) z = -AngleMax;
      mag = (x * 64'sd652032874 + (64'sd1 <<< 42)) >>> 43;
      if (mag > SpeedMax) mag = SpeedMax;
      if (mag < 0) mag = 0;
      ang = z[14:0];
      spd = flip ? 17'(-mag) : mag[16:0];
   endfunction

   function automatic wheels_t predict_wheels(input twist_t t);
      wheels_t r;
      longint ww, wl, cx, cy;
      int sx[4] = '{-1, 1, -1, 1};
      int sy[4] = '{1, 1, -1, -1};
      ww = longint'(t.yaw) * longint'(track_mm);
      wl = longint'(t.yaw) * longint'(base_mm);
      for (int k = 0; k < 4; k++) begin
         cx = longint'(t.fwd) * 8192 - sy[k] * wl;
         cy = longint'(t.side) * 8192 + sx[k] * ww;
         solve_wheel(cx, cy, r.ang[k], r.spd[k]);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH item %0d: %s", wheel_sets_seen, msg);
      errors++;
   endtask

   // Sender: twists change on the falling edge, held until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_took) begin
         req_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
         req_tvalid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (twist_queue.size() > 0) begin
         req_tdata <= twist_queue.pop_front();
         req_tvalid <= 1'b1;
         send_gap <= pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         rsp_tready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else if (!long_hold_done && twists_taken >= 400) begin
         rsp_tready <= 1'b0;
         recv_gap <= 300;
         long_hold_done <= 1'b1;
      end else if (pick_gap() > 0) begin
         rsp_tready <= 1'b0;
         recv_gap <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      wheels_t got, want;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("four_wheel_steer_kinematics_tb: done, errors");
         $finish;
      end
      req_took = !reset && req_tvalid && req_tready;
      if (req_took) begin
         wheel_expect.push_back(predict_wheels(twist_t'(req_tdata)));
         twists_taken++;
      end
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == RegTrack) track_mm = csr_data;
         else if (csr_index == RegBase) base_mm = csr_data;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = wheels_t'(rsp_tdata);
         wheel_sets_seen++;
         if (wheel_expect.size() == 0) begin
            report_mismatch("unexpected item");
         end else begin
            want = wheel_expect.pop_front();
            for (int k = 0; k < 4; k++) begin
               if (got.ang[k] !== want.ang[k])
                  report_mismatch($sformatf("angle[%0d]: got %0d expected %0d", k,
                                            $signed(got.ang[k]), $signed(want.ang[k])));
               if (got.spd[k] !== want.spd[k])
                  report_mismatch($sformatf("speed[%0d]: got %0d expected %0d", k,
                                            $signed(got.spd[k]), $signed(want.spd[k])));
            end
         end
      end
   end

   task automatic send(input int fwd, input int side, input int yaw);
      twist_t t;
      t.fwd = fwd[15:0];
      t.side = side[15:0];
      t.yaw = yaw[15:0];
      twist_queue.push_back(t);
   endtask

   task automatic drain();
      while (twist_queue.size() > 0 || req_tvalid || wheel_expect.size() > 0)
         @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int rand_field();
      int r;
      r = $urandom_range(9);
      if (r < 5) return $signed(16'($urandom()));
      if (r < 8) return $urandom_range(400) - 200;
      case ($urandom_range(3))
         0: return 32767;
         1: return -32768;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   task automatic random_twists(input int count);
      for (int i = 0; i < count; i++)
         send(rand_field(), rand_field(), rand_field());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset geometry: extremes of every field, pure yaw and pure translation.
      send(0, 0, 0);
      send(32767, 0, 0);
      send(-32768, 0, 0);
      send(0, 32767, 0);
      send(0, -32768, 0);
      send(0, 0, 32767);
      send(0, 0, -32768);
      send(32767, 32767, 32767);
      send(-32768, -32768, -32768);
      send(-1, 1, -1);
      send(1, -1, 1);
      send(0, 0, 4096);
      random_twists(230);
      drain();

      // No geometry: every wheel sees the same vector, zero when the body is still.
      write_reg(RegTrack, 12'd0);
      write_reg(RegBase, 12'd0);
      send(0, 0, 32767);
      send(0, 0, -32768);
      send(-5, 0, 1234);
      random_twists(220);
      drain();

      // Largest geometry: wheel speeds saturate.
      write_reg(RegTrack, 12'd4095);
      write_reg(RegBase, 12'd4095);
      send(-32768, -32768, -32768);
      send(32767, 32767, 32767);
      send(-32768, 32767, 32767);
      send(32767, -32768, -32768);
      send(0, 0, 32767);
      idle_on = 1'b0;
      random_twists(250);
      drain();
      idle_on = 1'b1;

      // Writes to unused indexes must leave the geometry alone.
      write_reg(RegSpareA, 12'd17);
      write_reg(RegSpareB, 12'hFFF);
      random_twists(100);
      drain();

      for (int p = 0; p < 3; p++) begin
         write_reg(RegTrack, 12'($urandom()));
         write_reg(RegBase, 12'($urandom()));
         random_twists(230);
         drain();
      end

      // Back to the default geometry, then one clean burst with no idling.
      write_reg(RegTrack, 12'd650);
      write_reg(RegBase, 12'd954);
      idle_on = 1'b0;
      random_twists(100);
      drain();

      $display("Covered %0d twists over several track and wheelbase settings,", twists_taken);
      $display("with long receiver stalls, zero geometry and saturated speeds.");
      if (errors == 0 && wheel_expect.size() == 0)
         $display("four_wheel_steer_kinematics_tb: done, clean");
      else
         $display("four_wheel_steer_kinematics_tb: done, errors");
      $finish;
   end

endmodule

### sim.f
sv/fwsk_pkg.sv
sv/fwsk_cell.sv
sv/fwsk_finish.sv
sv/four_wheel_steer_kinematics.sv
tb/four_wheel_steer_kinematics_tb.sv
